FILE: rtl/core/scdt_pkg.sv
// ----------------------------------------------------------------------------
// scdt_pkg
// shared types and constants of the dual interval timer with status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scdt_pkg;

  // default parameter values
  localparam int TICK_DIVIDER_DEF = 144;
  localparam int BUSY_CYCLES_DEF  = 192;
  localparam int B_PRESCALE_DEF   = 16;

  // field widths
  localparam int ADDR_W   = 8;
  localparam int DATA_W   = 8;
  localparam int CYC_W    = 12;
  localparam int RAW_A_W  = 10;
  localparam int CNT_A_W  = 11;
  localparam int CNT_B_W  = 13;
  localparam int BUSY_W   = 8;
  localparam int PRE_W    = 4;
  localparam int PULSE_W  = 6;
  // remainder (below 256) plus a full cycle count
  localparam int ACC_W    = 13;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 16;

  // item kinds
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // register addresses in bank 0
  localparam logic [ADDR_W-1:0] ADDR_TA_HI = 8'h24;
  localparam logic [ADDR_W-1:0] ADDR_TA_LO = 8'h25;
  localparam logic [ADDR_W-1:0] ADDR_TB    = 8'h26;
  localparam logic [ADDR_W-1:0] ADDR_CTRL  = 8'h27;

  localparam logic [1:0] MODE_CSM = 2'b10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } scdt_state_e;

  typedef struct packed {
    logic accept;   // latch a new item
    logic tick;     // process one timer A tick
    logic capture;  // load the output register
  } scdt_cmd_t;

  typedef struct packed {
    logic tick_pending;  // accumulator still holds a full tick
  } scdt_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/sound_chip_dual_timer_status_top.sv
// ----------------------------------------------------------------------------
// sound_chip_dual_timer_status_top
// timer and status section of an fm sound chip
// ----------------------------------------------------------------------------
// usage
//   slave stream: one item is a register write (tuser 0) or an advance of
//   the master clock by cycle_count cycles (tuser 1)
//   master stream: one result item per input item, carrying the status byte
//   after the item, the csm key pulses of an advance and the ch3 mode
// sequencing
//   a write is accepted, then its result is loaded into the output register;
//   an advance runs the timer A ticks it covers in between ((remainder +
//   cycle_count) / TICK_DIVIDER ticks, up to 29 at the default divider);
//   the tick unit handles one tick per cycle and one item is in work at a
//   time, the next item is taken in the cycle after the result is loaded
// reset
//   timers stopped, periods 1024 and 4096, flags and busy cleared
// stalls
//   the result sits in an output register; while it waits the block still
//   takes and works the next item, and holds before emitting its result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sound_chip_dual_timer_status_top #(
  parameter int TICK_DIVIDER = scdt_pkg::TICK_DIVIDER_DEF,
  parameter int BUSY_CYCLES  = scdt_pkg::BUSY_CYCLES_DEF,
  parameter int B_PRESCALE   = scdt_pkg::B_PRESCALE_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [0] port_sel, [8:1] reg_addr, [16:9] wdata, [28:17] cycle_count
  input  wire [scdt_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  // [0] cmd
  input  wire                              s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  wire                              m_axis_tready_i,
  // [7:0] status_byte, [13:8] csm_pulses, [14] ch3_special
  output logic [scdt_pkg::M_TDATA_W-1:0]   m_axis_tdata_o
);

  scdt_pkg::scdt_cmd_t cmd;
  scdt_pkg::scdt_sts_t sts;

  logic [7:0]                   status_byte;
  logic [scdt_pkg::PULSE_W-1:0] csm_pulses;
  logic                         ch3_special;

  // sequencer
  scdt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // timer state and output register
  scdt_dp #(
    .TICK_DIVIDER (TICK_DIVIDER),
    .BUSY_CYCLES  (BUSY_CYCLES),
    .B_PRESCALE   (B_PRESCALE)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (s_axis_tuser_i),
    .port_sel_i    (s_axis_tdata_i[0]),
    .reg_addr_i    (s_axis_tdata_i[8:1]),
    .wdata_i       (s_axis_tdata_i[16:9]),
    .cycle_count_i (s_axis_tdata_i[28:17]),
    .status_byte_o (status_byte),
    .csm_pulses_o  (csm_pulses),
    .ch3_special_o (ch3_special)
  );

  // bits 31:29 of the slave data are padding
  assign m_axis_tdata_o = {1'b0, ch3_special, csm_pulses, status_byte};

endmodule

`default_nettype wire

FILE: rtl/core/scdt_ctrl.sv
// ----------------------------------------------------------------------------
// scdt_ctrl
// sequencer: accept an item, run its ticks, hand the result to the output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scdt_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_valid_i,
  output logic                 s_ready_o,
  output logic                 m_valid_o,
  input  wire                  m_ready_i,
  input  scdt_pkg::scdt_sts_t  sts_i,
  output scdt_pkg::scdt_cmd_t  cmd_o
);

  scdt_pkg::scdt_state_e state_q, state_d;
  logic m_valid_q, m_valid_d;
  logic out_free;

  assign out_free = !m_valid_q || m_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scdt_pkg::ST_IDLE: begin
        if (s_valid_i) state_d = scdt_pkg::ST_RUN;
      end
      scdt_pkg::ST_RUN: begin
        if (!sts_i.tick_pending) state_d = scdt_pkg::ST_EMIT;
      end
      scdt_pkg::ST_EMIT: begin
        if (out_free) state_d = scdt_pkg::ST_IDLE;
      end
      default: state_d = scdt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    m_valid_d = m_valid_q && !m_ready_i;
    unique case (state_q)
      scdt_pkg::ST_IDLE: begin
        s_ready_o    = 1'b1;
        cmd_o.accept = s_valid_i;
      end
      scdt_pkg::ST_RUN: begin
        cmd_o.tick = sts_i.tick_pending;
      end
      scdt_pkg::ST_EMIT: begin
        cmd_o.capture = out_free;
        if (out_free) m_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= scdt_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/scdt_dp.sv
// ----------------------------------------------------------------------------
// scdt_dp
// timer state, register decode, tick unit and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scdt_dp #(
  parameter int TICK_DIVIDER = scdt_pkg::TICK_DIVIDER_DEF,
  parameter int BUSY_CYCLES  = scdt_pkg::BUSY_CYCLES_DEF,
  parameter int B_PRESCALE   = scdt_pkg::B_PRESCALE_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  scdt_pkg::scdt_cmd_t                 cmd_i,
  output scdt_pkg::scdt_sts_t                 sts_o,
  input  wire                                 kind_i,
  input  wire                                 port_sel_i,
  input  wire [scdt_pkg::ADDR_W-1:0]          reg_addr_i,
  input  wire [scdt_pkg::DATA_W-1:0]          wdata_i,
  input  wire [scdt_pkg::CYC_W-1:0]           cycle_count_i,
  output logic [7:0]                          status_byte_o,
  output logic [scdt_pkg::PULSE_W-1:0]        csm_pulses_o,
  output logic                                ch3_special_o
);

  localparam int ACC_W = scdt_pkg::ACC_W;
  localparam int PCW   = scdt_pkg::PRE_W + 1;
  localparam logic [ACC_W-1:0] TICK_STEP = ACC_W'(TICK_DIVIDER);
  localparam logic [PCW-1:0]   PRE_WRAP  = PCW'(B_PRESCALE);
  localparam logic [scdt_pkg::BUSY_W-1:0] BUSY_LOAD = scdt_pkg::BUSY_W'(BUSY_CYCLES);
  localparam logic [scdt_pkg::PULSE_W-1:0] PULSE_MAX = '1;

  logic [scdt_pkg::RAW_A_W-1:0] raw_a_q;
  logic [scdt_pkg::DATA_W-1:0]  tb_data_q;
  logic [scdt_pkg::CNT_A_W-1:0] cnt_a_q;
  logic [scdt_pkg::CNT_B_W-1:0] cnt_b_q;
  logic                         run_a_q, run_b_q, csm_q, special_q;
  logic                         flag_a_q, flag_b_q, flag_busy_q;
  logic [scdt_pkg::BUSY_W-1:0]  busy_q;
  logic [ACC_W-1:0]             acc_q;
  logic [scdt_pkg::PRE_W-1:0]   pre_q;
  logic [scdt_pkg::PULSE_W-1:0] pulses_q;

  logic [scdt_pkg::CNT_A_W-1:0] period_a;
  logic [scdt_pkg::CNT_B_W-1:0] period_b;
  logic [scdt_pkg::CNT_A_W-1:0] cnt_a_dec;
  logic [scdt_pkg::CNT_B_W-1:0] cnt_b_dec;
  logic [PCW-1:0]               pre_inc;
  logic [8:0]                   tb_steps;
  logic                         bank0;

  // period A = 1024 - raw, period B = 16 * (256 - data)
  assign period_a  = 11'h400 - {1'b0, raw_a_q};
  assign tb_steps  = 9'h100 - {1'b0, tb_data_q};
  assign period_b  = {tb_steps, 4'b0000};
  assign cnt_a_dec = cnt_a_q - 1'b1;
  assign cnt_b_dec = cnt_b_q - 1'b1;
  assign pre_inc   = {1'b0, pre_q} + 1'b1;
  assign bank0     = (port_sel_i == 1'b0);

  assign sts_o.tick_pending = (acc_q >= TICK_STEP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_a_q     <= '0;
      tb_data_q   <= '0;
      cnt_a_q     <= 11'h400;
      cnt_b_q     <= 13'h1000;
      run_a_q     <= 1'b0;
      run_b_q     <= 1'b0;
      csm_q       <= 1'b0;
      special_q   <= 1'b0;
      flag_a_q    <= 1'b0;
      flag_b_q    <= 1'b0;
      flag_busy_q <= 1'b0;
      busy_q      <= '0;
      acc_q       <= '0;
      pre_q       <= '0;
      pulses_q    <= '0;
    end else if (cmd_i.accept) begin
      pulses_q <= '0;
      if (kind_i == scdt_pkg::CMD_WRITE) begin
        flag_busy_q <= 1'b1;
        busy_q      <= BUSY_LOAD;
        if (bank0) begin
          unique case (reg_addr_i)
            scdt_pkg::ADDR_TA_HI: raw_a_q   <= {wdata_i, raw_a_q[1:0]};
            scdt_pkg::ADDR_TA_LO: raw_a_q   <= {raw_a_q[9:2], wdata_i[1:0]};
            scdt_pkg::ADDR_TB:    tb_data_q <= wdata_i;
            scdt_pkg::ADDR_CTRL: begin
              if (wdata_i[0] && !run_a_q) cnt_a_q <= period_a;
              if (wdata_i[1] && !run_b_q) cnt_b_q <= period_b;
              run_a_q <= wdata_i[2];
              run_b_q <= wdata_i[3];
              if (wdata_i[4]) flag_a_q <= 1'b0;
              if (wdata_i[5]) flag_b_q <= 1'b0;
              special_q <= (wdata_i[7:6] != 2'b00);
              csm_q     <= (wdata_i[7:6] == scdt_pkg::MODE_CSM);
            end
            default: ;
          endcase
        end
      end else begin
        // busy countdown stops at zero
        if (busy_q != '0) begin
          if ({4'b0, busy_q} > cycle_count_i) begin
            busy_q <= busy_q - cycle_count_i[scdt_pkg::BUSY_W-1:0];
          end else begin
            busy_q      <= '0;
            flag_busy_q <= 1'b0;
          end
        end
        acc_q <= acc_q + {1'b0, cycle_count_i};
      end
    end else if (cmd_i.tick) begin
      acc_q <= acc_q - TICK_STEP;
      if (run_a_q) begin
        if (cnt_a_dec == '0) begin
          flag_a_q <= 1'b1;
          cnt_a_q  <= period_a;
          if (csm_q && (pulses_q != PULSE_MAX)) pulses_q <= pulses_q + 1'b1;
        end else begin
          cnt_a_q <= cnt_a_dec;
        end
      end
      if (pre_inc >= PRE_WRAP) begin
        pre_q <= '0;
        if (run_b_q) begin
          if (cnt_b_dec == '0) begin
            flag_b_q <= 1'b1;
            cnt_b_q  <= period_b;
          end else begin
            cnt_b_q <= cnt_b_dec;
          end
        end
      end else begin
        pre_q <= pre_inc[scdt_pkg::PRE_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      status_byte_o <= {flag_busy_q, 5'b00000, flag_b_q, flag_a_q};
      csm_pulses_o  <= pulses_q;
      ch3_special_o <= special_q;
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb_sound_chip_dual_timer_status_top.sv
// ----------------------------------------------------------------------------
// tb_sound_chip_dual_timer_status_top
// self-checking bench for the dual interval timer with status: a queue-fed
// stream driver, a result monitor and an item-level model of both timers, the
// busy countdown and the mode bits, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_sound_chip_dual_timer_status_top;

  localparam int TICK_DIV    = scdt_pkg::TICK_DIVIDER_DEF;
  localparam int BUSY_LOAD   = scdt_pkg::BUSY_CYCLES_DEF;
  localparam int B_DIV       = scdt_pkg::B_PRESCALE_DEF;
  // long receiver hold-off, started once enough items went in
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 600;
  // leave plenty of room after the last item
  localparam int TAIL_CYCLES = 80;
  localparam int CYCLE_LIMIT = 1000000;

  // one input item of the slave stream
  typedef struct packed {
    logic             cmd;
    logic             port_sel;
    logic [7:0]       reg_addr;
    logic [7:0]       wdata;
    logic [11:0]      cycle_count;
  } timer_item_t;

  // one result item of the master stream
  typedef struct packed {
    logic [7:0]       status_byte;
    logic [5:0]       csm_pulses;
    logic             ch3_special;
  } status_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                            s_tvalid = 1'b0;
  logic [scdt_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
  logic                            s_tuser  = 1'b0;
  logic                            m_tready = 1'b0;
  wire                             s_axis_tready_o;
  wire                             m_axis_tvalid_o;
  wire  [scdt_pkg::M_TDATA_W-1:0]  m_axis_tdata_o;

  sound_chip_dual_timer_status_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    // [0] port_sel, [8:1] reg_addr, [16:9] wdata, [28:17] cycle_count
    .s_axis_tdata_i  (s_tdata),
    // [0] cmd
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    // [7:0] status_byte, [13:8] csm_pulses, [14] ch3_special
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // timer model state, mirrors the block after each accepted item
  // --------------------------------------------------------------------------
  logic [9:0]  ta_raw    = '0;
  logic [10:0] ta_period = 11'h400;
  logic [10:0] ta_count  = 11'h400;
  logic        ta_run    = 1'b0;
  logic [12:0] tb_period = 13'h1000;
  logic [12:0] tb_count  = 13'h1000;
  logic        tb_run    = 1'b0;
  logic        csm_on    = 1'b0;
  logic        ch3_on    = 1'b0;
  logic [2:0]  flags     = '0;   // bit0 timer A, bit1 timer B, bit2 busy
  logic [7:0]  busy_cnt  = '0;
  logic [7:0]  tick_rem  = '0;   // master cycles gathered toward the next A tick
  logic [3:0]  b_div     = '0;   // A ticks since the last B tick

  timer_item_t host_cmd_q[$];    // items waiting for the driver
  status_t     status_due_q[$];  // results owed by the block, oldest first
  timer_item_t bus_item;

  int n_taken    = 0;
  int n_results  = 0;
  int n_mismatch = 0;
  int n_cycles   = 0;

  int      tx_gap    = 0;
  int      tx_quiet  = 0;
  int      rx_stall  = 0;
  int      rx_quiet  = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;
  status_t got;
  status_t want;

  // apply one item to the model and return the result it should produce
  function automatic status_t timer_step_predict(input timer_item_t it);
    status_t r;
    int      acc;
    int      pre;
    int      pulses;
    pulses = 0;
    if (it.cmd == scdt_pkg::CMD_WRITE) begin
      flags[2] = 1'b1;
      busy_cnt = 8'(BUSY_LOAD);
      if (it.port_sel == 1'b0) begin
        case (it.reg_addr)
          scdt_pkg::ADDR_TA_HI: begin
            ta_raw    = {it.wdata, ta_raw[1:0]};
            ta_period = 11'h400 - 11'(ta_raw);
          end
          scdt_pkg::ADDR_TA_LO: begin
            ta_raw    = {ta_raw[9:2], it.wdata[1:0]};
            ta_period = 11'h400 - 11'(ta_raw);
          end
          scdt_pkg::ADDR_TB: tb_period = 13'((256 - int'(it.wdata)) * 16);
          scdt_pkg::ADDR_CTRL: begin
            // reload tests look at the run bits from before this write
            if (it.wdata[0] && !ta_run) ta_count = ta_period;
            if (it.wdata[1] && !tb_run) tb_count = tb_period;
            ta_run = it.wdata[2];
            tb_run = it.wdata[3];
            if (it.wdata[4]) flags[0] = 1'b0;
            if (it.wdata[5]) flags[1] = 1'b0;
            ch3_on = (it.wdata[7:6] != 2'b00);
            csm_on = (it.wdata[7:6] == scdt_pkg::MODE_CSM);
          end
          default: ;
        endcase
      end
    end else begin
      // busy countdown saturates at zero, a zero-cycle advance changes nothing
      if (busy_cnt != 0) begin
        if (busy_cnt > it.cycle_count) busy_cnt = busy_cnt - 8'(it.cycle_count);
        else busy_cnt = '0;
        if (busy_cnt == 0) flags[2] = 1'b0;
      end
      acc = int'(tick_rem) + int'(it.cycle_count);
      pre = int'(b_div);
      while (acc >= TICK_DIV) begin
        acc -= TICK_DIV;
        if (ta_run) begin
          ta_count = ta_count - 11'd1;
          if (ta_count == 0) begin
            flags[0] = 1'b1;
            ta_count = ta_period;
            if (csm_on && pulses < 63) pulses++;
          end
        end
        pre++;
        if (pre >= B_DIV) begin
          pre = 0;
          if (tb_run) begin
            tb_count = tb_count - 13'd1;
            if (tb_count == 0) begin
              flags[1] = 1'b1;
              tb_count = tb_period;
            end
          end
        end
      end
      tick_rem = 8'(acc);
      b_div    = 4'(pre);
    end
    r.status_byte = {flags[2], 5'b00000, flags[1:0]};
    r.csm_pulses  = 6'(pulses);
    r.ch3_special = ch3_on;
    return r;
  endfunction

  // advance item; the unused write fields carry random bits
  function automatic timer_item_t mk_advance(input logic [11:0] cycles);
    timer_item_t it;
    it             = timer_item_t'($urandom);
    it.cmd         = scdt_pkg::CMD_ADVANCE;
    it.cycle_count = cycles;
    return it;
  endfunction

  // write item; the unused cycle count carries random bits
  function automatic timer_item_t mk_write(input logic port, input logic [7:0] addr,
                                           input logic [7:0] data);
    timer_item_t it;
    it          = mk_advance(12'($urandom));
    it.cmd      = scdt_pkg::CMD_WRITE;
    it.port_sel = port;
    it.reg_addr = addr;
    it.wdata    = data;
    return it;
  endfunction

  // mostly timer programming and advances, some writes elsewhere as noise
  function automatic timer_item_t random_item();
    timer_item_t it;
    int          pick;
    it   = mk_advance(12'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) it.cycle_count = '0;
      else if (pick == 1) it.cycle_count = '1;
      else if (pick < 5) it.cycle_count = 12'($urandom_range(1, 300));
    end else if (pick < 85) begin
      it.cmd      = scdt_pkg::CMD_WRITE;
      it.port_sel = 1'b0;
      case ($urandom_range(0, 3))
        0: begin
          // short A periods so underflows and csm pulses come often
          it.reg_addr = scdt_pkg::ADDR_TA_HI;
          if ($urandom_range(0, 1) == 1) it.wdata = 8'($urandom_range(240, 255));
        end
        1: it.reg_addr = scdt_pkg::ADDR_TA_LO;
        2: begin
          it.reg_addr = scdt_pkg::ADDR_TB;
          if ($urandom_range(0, 2) != 0) it.wdata = 8'($urandom_range(248, 255));
        end
        default: begin
          it.reg_addr = scdt_pkg::ADDR_CTRL;
          if ($urandom_range(0, 3) != 0) it.wdata[3:2] = 2'b11;
        end
      endcase
    end else begin
      it.cmd = scdt_pkg::CMD_WRITE;
      // timer addresses in a random bank now and then
      if ($urandom_range(0, 1) == 1) it.reg_addr = 8'($urandom_range(8'h24, 8'h27));
    end
    return it;
  endfunction

  // short idles are common, long ones rare
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic log_mismatch(input string what);
    n_mismatch++;
    if (n_mismatch <= 10) $display("mismatch at result %0d: %s", n_results, what);
  endtask

  // block until every queued item went in and every result came back
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (host_cmd_q.size() != 0 || s_tvalid || status_due_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // driver: offers queued items, predicts each one at its handshake
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_axis_tready_o) begin
        status_due_q.push_back(timer_step_predict(bus_item));
        n_taken++;
      end
      if (!s_tvalid || s_axis_tready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (host_cmd_q.size() != 0) begin
          bus_item = host_cmd_q.pop_front();
          s_tdata  <= {3'b000, bus_item.cycle_count, bus_item.wdata,
                       bus_item.reg_addr, bus_item.port_sel};
          s_tuser  <= bus_item.cmd;
          s_tvalid <= 1'b1;
          // idle after this item, or a stretch of back-to-back items
          if (tx_quiet > 0) tx_quiet--;
          else if ($urandom_range(0, 99) < 4) tx_quiet = $urandom_range(40, 100);
          else tx_gap = pick_idle();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: drives tready, checks each result against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (m_axis_tvalid_o && m_tready) begin
        got.status_byte = m_axis_tdata_o[7:0];
        got.csm_pulses  = m_axis_tdata_o[13:8];
        got.ch3_special = m_axis_tdata_o[14];
        if (status_due_q.size() == 0) begin
          log_mismatch($sformatf("unexpected item status %02h pulses %0d ch3 %0b",
                                 got.status_byte, got.csm_pulses, got.ch3_special));
        end else begin
          want = status_due_q.pop_front();
          if (got.status_byte != want.status_byte || got.csm_pulses != want.csm_pulses ||
              got.ch3_special != want.ch3_special)
            log_mismatch($sformatf(
              "expected status %02h pulses %0d ch3 %0b, got status %02h pulses %0d ch3 %0b",
              want.status_byte, want.csm_pulses, want.ch3_special,
              got.status_byte, got.csm_pulses, got.ch3_special));
        end
        n_results++;
      end
      // one long hold-off while the sender keeps pushing, so the input backs up
      if (!hold_done && n_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_quiet > 0) begin
        rx_quiet--;
        m_tready <= 1'b1;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 99) < 4) rx_quiet = $urandom_range(40, 100);
        else rx_stall = pick_idle();
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("FAIL sound_chip_dual_timer_status_top");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // out of reset: nothing runs, flags clear
    host_cmd_q.push_back(mk_advance(12'd0));
    host_cmd_q.push_back(mk_advance(12'hFFF));
    // writes that miss the timer registers only raise busy
    host_cmd_q.push_back(mk_write(1'b1, scdt_pkg::ADDR_CTRL, 8'hFF));
    host_cmd_q.push_back(mk_write(1'b0, 8'h00, 8'h00));
    // busy release: zero cycles keep it, then count it down in two steps
    host_cmd_q.push_back(mk_advance(12'd0));
    host_cmd_q.push_back(mk_advance(12'd100));
    host_cmd_q.push_back(mk_advance(12'd92));
    // shortest periods, load and start both timers in csm mode
    host_cmd_q.push_back(mk_write(1'b0, scdt_pkg::ADDR_TA_HI, 8'hFF));
    host_cmd_q.push_back(mk_write(1'b0, scdt_pkg::ADDR_TA_LO, 8'h03));
    host_cmd_q.push_back(mk_write(1'b0, scdt_pkg::ADDR_TB, 8'hFF));
    host_cmd_q.push_back(mk_write(1'b0, scdt_pkg::ADDR_CTRL, 8'h8F));
    // full advances: a pulse per A tick, B underflows after 16 B ticks
    repeat (10) host_cmd_q.push_back(mk_advance(12'hFFF));
    // clear both flags and stop, then ch3 mode without csm
    host_cmd_q.push_back(mk_write(1'b0, scdt_pkg::ADDR_CTRL, 8'h30));
    host_cmd_q.push_back(mk_write(1'b0, scdt_pkg::ADDR_CTRL, 8'h40));
    // longest periods, and the top of the address space in bank 1
    host_cmd_q.push_back(mk_write(1'b0, scdt_pkg::ADDR_TA_HI, 8'h00));
    host_cmd_q.push_back(mk_write(1'b0, scdt_pkg::ADDR_TA_LO, 8'h00));
    host_cmd_q.push_back(mk_write(1'b0, scdt_pkg::ADDR_TB, 8'h00));
    host_cmd_q.push_back(mk_write(1'b1, 8'hFF, 8'hFF));
    wait_quiet();

    // first random batch; the long receiver hold lands inside it
    repeat (450) host_cmd_q.push_back(random_item());
    // sender holds back until every result is in
    wait_quiet();

    repeat (500) host_cmd_q.push_back(random_item());
    wait_quiet();

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (n_mismatch == 0 && status_due_q.size() == 0) begin
      $display("PASS sound_chip_dual_timer_status_top");
    end else begin
      $display("FAIL sound_chip_dual_timer_status_top");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/scdt_pkg.sv
rtl/core/scdt_ctrl.sv
rtl/core/scdt_dp.sv
rtl/core/sound_chip_dual_timer_status_top.sv
verif/tb_sound_chip_dual_timer_status_top.sv
